>>> rtl/core/vtx_pkg.sv
// shared types and constants for the vertex transform pipeline
package vtx_pkg;

    // vertex and matrix geometry
    localparam int VEC_LEN    = 4;
    localparam int NUM_ROWS   = 4;
    localparam int NUM_COEF   = NUM_ROWS * VEC_LEN;
    localparam int NUM_PAIRS  = NUM_COEF / 2;
    localparam int PAIR_IDX_W = $clog2(NUM_PAIRS);

    // port widths
    localparam int DATA_W      = 32;
    localparam int CFG_DATA_W  = 64;
    localparam int CFG_INDEX_W = 4;

    // register stages: multiply, pair add, row sum, shift and saturate
    localparam int NUM_STAGES = 4;

    // 1.0 in Q16.16, the diagonal of the matrix after reset
    localparam logic [DATA_W-1:0] COEF_ONE = 32'h0001_0000;

    // saturation limits
    localparam logic [DATA_W-1:0] SAT_MAX = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] SAT_MIN = 32'h8000_0000;

    // per-stage load enables handed from the control to the datapath
    typedef struct packed {
        logic mul;
        logic pair;
        logic sum;
        logic sat;
    } stage_ctrl_t;

endpackage

>>> rtl/core/vtx_coef_regs.sv
// coefficient register file, written through the configuration port
module vtx_coef_regs #(
    parameter int COEF_WIDTH = 32
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_valid,
    input  logic [vtx_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [vtx_pkg::CFG_DATA_W-1:0]       cfg_data,
    output logic signed [COEF_WIDTH-1:0]         coef [vtx_pkg::NUM_COEF]
);
    import vtx_pkg::*;

    logic [COEF_WIDTH-1:0]  coef_reg [NUM_COEF];
    logic [PAIR_IDX_W-1:0]  pair_idx;
    logic                   idx_hit;

    // writes beyond the last pair are dropped
    assign pair_idx = cfg_index[PAIR_IDX_W-1:0];
    assign idx_hit  = (cfg_index < CFG_INDEX_W'(NUM_PAIRS));

    // register file, identity matrix after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_COEF; i++)
            begin
                if ((i % (VEC_LEN + 1)) == 0)
                    coef_reg[i] <= COEF_ONE[COEF_WIDTH-1:0];
                else
                    coef_reg[i] <= '0;
            end
        end
        else if (cfg_valid && idx_hit)
        begin
            coef_reg[{pair_idx, 1'b0}] <= cfg_data[COEF_WIDTH-1:0];
            coef_reg[{pair_idx, 1'b1}] <= cfg_data[DATA_W +: COEF_WIDTH];
        end
    end

    // coefficients as signed values
    always_comb
    begin
        for (int i = 0; i < NUM_COEF; i++)
            coef[i] = $signed(coef_reg[i]);
    end

endmodule

>>> rtl/core/vtx_row_unit.sv
// one matrix row: four multiplies, adder tree, floor shift and saturation
module vtx_row_unit #(
    parameter int COEF_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                                  clk,
    input  vtx_pkg::stage_ctrl_t                  ctrl,
    input  logic signed [COEF_WIDTH-1:0]          coef [vtx_pkg::VEC_LEN],
    input  logic signed [vtx_pkg::DATA_W-1:0]     vtx  [vtx_pkg::VEC_LEN],
    output logic signed [vtx_pkg::DATA_W-1:0]     res,
    output logic                                  ovf
);
    import vtx_pkg::*;

    localparam int PW = COEF_WIDTH + DATA_W;
    localparam int SW = PW + 2;

    logic signed [PW-1:0]     prod_reg  [VEC_LEN];
    logic signed [PW-1:0]     prod_next [VEC_LEN];
    logic signed [PW:0]       pair_reg  [2];
    logic signed [PW:0]       pair_next [2];
    logic signed [SW-1:0]     sum_reg;
    logic signed [SW-1:0]     sum_next;
    logic signed [SW-1:0]     shifted;
    logic [SW-DATA_W:0]       upper;
    logic                     fits;
    logic [DATA_W-1:0]        res_reg;
    logic [DATA_W-1:0]        res_next;
    logic                     ovf_reg;
    logic                     ovf_next;

    // stage 1: exact products
    always_comb
    begin
        for (int k = 0; k < VEC_LEN; k++)
            prod_next[k] = PW'(coef[k]) * PW'(vtx[k]);
    end

    // stage 2: pairwise sums
    always_comb
    begin
        for (int j = 0; j < 2; j++)
            pair_next[j] = (PW + 1)'(prod_reg[2 * j]) + (PW + 1)'(prod_reg[2 * j + 1]);
    end

    // stage 3: full row sum
    assign sum_next = SW'(pair_reg[0]) + SW'(pair_reg[1]);

    // stage 4: floor shift, then clamp to 32 bits
    assign shifted  = sum_reg >>> FRAC_BITS;
    assign upper    = shifted[SW-1:DATA_W-1];
    assign fits     = (&upper) || !(|upper);
    assign ovf_next = !fits;

    always_comb
    begin
        if (fits)
            res_next = shifted[DATA_W-1:0];
        else if (shifted[SW-1])
            res_next = SAT_MIN;
        else
            res_next = SAT_MAX;
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (ctrl.mul)
            prod_reg <= prod_next;
        if (ctrl.pair)
            pair_reg <= pair_next;
        if (ctrl.sum)
            sum_reg <= sum_next;
        if (ctrl.sat)
        begin
            res_reg <= res_next;
            ovf_reg <= ovf_next;
        end
    end

    assign res = $signed(res_reg);
    assign ovf = ovf_reg;

endmodule

>>> rtl/core/vertex_transform_4x4_top.sv
// Pipeline: four register stages, from multiply through pair add and row sum to saturate.
// Throughput: one vertex per cycle without stalls; all sixteen 32x32 multipliers are in stage 1.
// Stalls: every stage holds its item while the next cannot load, so a bubble is filled at once.
// Reset: asynchronous, active low; empties the pipeline and loads the identity matrix.
// top level of the streaming 4x4 vertex transform
module vertex_transform_4x4_top #(
    parameter int COEF_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [vtx_pkg::CFG_INDEX_W-1:0]       cfg_index,
    input  logic [vtx_pkg::CFG_DATA_W-1:0]        cfg_data,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic signed [vtx_pkg::DATA_W-1:0]     in_x,
    input  logic signed [vtx_pkg::DATA_W-1:0]     in_y,
    input  logic signed [vtx_pkg::DATA_W-1:0]     in_z,
    input  logic signed [vtx_pkg::DATA_W-1:0]     in_w,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic signed [vtx_pkg::DATA_W-1:0]     out_x,
    output logic signed [vtx_pkg::DATA_W-1:0]     out_y,
    output logic signed [vtx_pkg::DATA_W-1:0]     out_z,
    output logic signed [vtx_pkg::DATA_W-1:0]     out_w,
    output logic                                  overflow
);
    import vtx_pkg::*;

    logic signed [COEF_WIDTH-1:0]  coef     [NUM_COEF];
    logic signed [COEF_WIDTH-1:0]  row_coef [NUM_ROWS][VEC_LEN];
    logic signed [DATA_W-1:0]      vtx      [VEC_LEN];
    logic signed [DATA_W-1:0]      row_res  [NUM_ROWS];
    logic [NUM_ROWS-1:0]           row_ovf;
    logic [NUM_STAGES-1:0]         valid_reg;
    logic [NUM_STAGES-1:0]         valid_next;
    logic [NUM_STAGES-1:0]         stage_en;
    stage_ctrl_t                   ctrl;

    // configuration writes are always taken
    assign cfg_ready = 1'b1;

    vtx_coef_regs #(
        .COEF_WIDTH (COEF_WIDTH)
    ) u_coef_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .coef      (coef)
    );

    // a stage may load when it is empty or its item moves on
    always_comb
    begin
        stage_en[NUM_STAGES-1] = !valid_reg[NUM_STAGES-1] || out_ready;
        for (int s = NUM_STAGES - 2; s >= 0; s--)
            stage_en[s] = !valid_reg[s] || stage_en[s + 1];
    end

    assign in_ready = stage_en[0];

    // valid bits follow the items
    always_comb
    begin
        valid_next = valid_reg;
        if (stage_en[0])
            valid_next[0] = in_valid;
        for (int s = 1; s < NUM_STAGES; s++)
        begin
            if (stage_en[s])
                valid_next[s] = valid_reg[s - 1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= valid_next;
    end

    // datapath loads only for a real item
    assign ctrl.mul  = stage_en[0] && in_valid;
    assign ctrl.pair = stage_en[1] && valid_reg[0];
    assign ctrl.sum  = stage_en[2] && valid_reg[1];
    assign ctrl.sat  = stage_en[3] && valid_reg[2];

    // vertex and matrix rows
    assign vtx[0] = in_x;
    assign vtx[1] = in_y;
    assign vtx[2] = in_z;
    assign vtx[3] = in_w;

    always_comb
    begin
        for (int r = 0; r < NUM_ROWS; r++)
        begin
            for (int k = 0; k < VEC_LEN; k++)
                row_coef[r][k] = coef[VEC_LEN * r + k];
        end
    end

    // one datapath per output component
    for (genvar r = 0; r < NUM_ROWS; r++)
    begin : g_row
        vtx_row_unit #(
            .COEF_WIDTH (COEF_WIDTH),
            .FRAC_BITS  (FRAC_BITS)
        ) u_row (
            .clk  (clk),
            .ctrl (ctrl),
            .coef (row_coef[r]),
            .vtx  (vtx),
            .res  (row_res[r]),
            .ovf  (row_ovf[r])
        );
    end

    // result item
    assign out_valid = valid_reg[NUM_STAGES-1];
    assign out_x     = row_res[0];
    assign out_y     = row_res[1];
    assign out_z     = row_res[2];
    assign out_w     = row_res[3];
    assign overflow  = |row_ovf;

endmodule

>>> rtl/core/vtx_checker.sv
// port-level checks for the vertex transform, bound to the top level
module vtx_checker (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    input  logic                                  in_ready,
    input  logic                                  out_valid,
    input  logic                                  out_ready,
    input  logic signed [vtx_pkg::DATA_W-1:0]     out_x,
    input  logic signed [vtx_pkg::DATA_W-1:0]     out_y,
    input  logic signed [vtx_pkg::DATA_W-1:0]     out_z,
    input  logic signed [vtx_pkg::DATA_W-1:0]     out_w,
    input  logic                                  overflow
);
    import vtx_pkg::*;

    // a stalled result item holds still
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_x) && $stable(out_y)
            && $stable(out_z) && $stable(out_w) && $stable(overflow))
        else $error("result item changed while stalled");

    // input back-pressure only comes from a stalled, full output
    a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input refused with room in the pipeline");

    // overflow flag goes with a clamped component
    a_ovf_clamped: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && overflow |->
            (out_x == SAT_MAX) || (out_x == SAT_MIN) || (out_y == SAT_MAX)
            || (out_y == SAT_MIN) || (out_z == SAT_MAX) || (out_z == SAT_MIN)
            || (out_w == SAT_MAX) || (out_w == SAT_MIN))
        else $error("overflow set without a saturated component");

    // no result item may appear straight out of reset
    a_reset_empty: assert property (@(posedge clk)
        !rst_n |=> !out_valid)
        else $error("result item present after reset");

endmodule

bind vertex_transform_4x4_top vtx_checker u_vtx_checker (.*);
